>>> sv/srsp_pkg.sv
// Shared types, codes and character tables for the status record stream parser.
// No dependencies; imported by every module of the block except srsp_fifo.
`timescale 1ns / 1ps
`default_nettype none
package srsp_pkg;

	localparam int DEF_COUNT_WIDTH = 32;
	localparam int DEF_QUEUE_DEPTH = 4;

	// parse phases
	localparam logic [3:0] PH_START        = 4'd0;
	localparam logic [3:0] PH_HDR_PREFIX   = 4'd1;
	localparam logic [3:0] PH_HDR_OTHER    = 4'd2;
	localparam logic [3:0] PH_HDR_WORD     = 4'd3;
	localparam logic [3:0] PH_HDR_UPSTREAM = 4'd4;
	localparam logic [3:0] PH_AB_AHEAD     = 4'd5;
	localparam logic [3:0] PH_AB_DASH      = 4'd6;
	localparam logic [3:0] PH_AB_BEHIND    = 4'd7;
	localparam logic [3:0] PH_FILE_SECOND  = 4'd8;
	localparam logic [3:0] PH_FILE_FIELDS  = 4'd9;
	localparam logic [3:0] PH_SKIP         = 4'd10;
	localparam logic [3:0] PH_RENAME_SRC   = 4'd11;
	localparam logic [3:0] PH_HALT         = 4'd12;

	// record kinds
	localparam logic [2:0] K_NONE = 3'd0;
	localparam logic [2:0] K_ORD  = 3'd1;
	localparam logic [2:0] K_REN  = 3'd2;
	localparam logic [2:0] K_UNM  = 3'd3;
	localparam logic [2:0] K_UNTR = 3'd4;
	localparam logic [2:0] K_HDR  = 3'd5;
	localparam logic [2:0] K_IGN  = 3'd6;

	// error codes
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_NO_TERM    = 3'd1;
	localparam logic [2:0] ERR_BAD_RECORD = 3'd2;
	localparam logic [2:0] ERR_BAD_HEADER = 3'd3;
	localparam logic [2:0] ERR_NO_SOURCE  = 3'd4;

	// register indexes
	localparam logic [0:0] REG_MAX_RETAINED = 1'd0;
	localparam logic [31:0] MAX_RETAINED_RESET = 32'd1024;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_QUEST = 8'h3f;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam logic [143:0] PFX_OID      = "# branch.oid ";
	localparam logic [143:0] PFX_HEAD     = "# branch.head ";
	localparam logic [143:0] PFX_UPSTREAM = "# branch.upstream ";
	localparam logic [143:0] PFX_AB       = "# branch.ab +";
	localparam logic [79:0]  WORD_INITIAL  = "(initial)";
	localparam logic [79:0]  WORD_DETACHED = "(detached)";

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_output;
	} item_t;

	typedef struct packed {
		logic [2:0]  error_code;
		logic [31:0] staged_count;
		logic [31:0] modified_count;
		logic [31:0] conflicted_count;
		logic [31:0] untracked_count;
		logic [63:0] ahead;
		logic [63:0] behind;
		logic        unborn;
		logic        detached;
		logic [31:0] retained_count;
		logic        files_truncated;
	} result_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0] data_byte;
		logic       eos;
		logic       is_nul;
		logic       is_digit;
		logic       is_space;
		logic [3:0] digit;
	} entry_t;

	function automatic logic [4:0] prefix_len(input logic [1:0] sel);
		logic [4:0] len;
		case (sel)
			2'd0: len = 5'd13;
			2'd1: len = 5'd14;
			2'd2: len = 5'd18;
			default: len = 5'd13;
		endcase
		return len;
	endfunction

	// character pos of header prefix sel; pos must be below its length
	function automatic logic [7:0] prefix_char(input logic [1:0] sel, input logic [4:0] pos);
		logic [143:0] vec;
		logic [4:0]   idx;
		case (sel)
			2'd0: vec = PFX_OID;
			2'd1: vec = PFX_HEAD;
			2'd2: vec = PFX_UPSTREAM;
			default: vec = PFX_AB;
		endcase
		idx = prefix_len(sel) - 5'd1 - pos;
		return vec[8*idx +: 8];
	endfunction

	// character pos of the initial (sel=1) or detached (sel=0) word
	function automatic logic [7:0] word_char(input logic sel, input logic [3:0] pos);
		logic [3:0] idx;
		logic [7:0] ch;
		if (sel) begin
			idx = 4'd8 - pos;
			ch = WORD_INITIAL[8*idx +: 8];
		end else begin
			idx = 4'd9 - pos;
			ch = WORD_DETACHED[8*idx +: 8];
		end
		return ch;
	endfunction

endpackage
`default_nettype wire

>>> sv/status_record_stream_parser.sv
// Status record stream parser, top level: front queue, back parser, register port.
// Throughput: one byte per cycle; full rises only once the four-entry front queue fills
// behind an end-of-stream entry that waits for the previous summary to be popped.
// An end-of-stream item passes through the front queue; its summary is registered when
// the back end takes it. Reset (arst_n low, asynchronous) clears all counters, flags and
// queues; max_retained_files returns to 1024. Depends on srsp_pkg, srsp_front, srsp_back.
`timescale 1ns / 1ps
`default_nettype none
module status_record_stream_parser #(
	parameter int COUNT_WIDTH = srsp_pkg::DEF_COUNT_WIDTH,
	parameter int QUEUE_DEPTH = srsp_pkg::DEF_QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire srsp_pkg::item_t   item,
	output logic                   full,
	output srsp_pkg::result_t      result,
	output logic                   empty,
	input  wire logic              pop,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [1:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import srsp_pkg::*;

	entry_t      entry;
	logic        entry_empty, take;
	logic [31:0] max_ret_q;

	assign pready = 1'b1;
	assign prdata = max_ret_q;

	// register write transfer; the single register decodes at index zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_ret_q <= MAX_RETAINED_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr[1:1] == REG_MAX_RETAINED) begin
			max_ret_q <= pwdata;
		end
	end

	srsp_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item       (item),
		.full       (full),
		.take       (take),
		.entry      (entry),
		.entry_empty(entry_empty)
	);

	srsp_back #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry       (entry),
		.entry_empty (entry_empty),
		.take        (take),
		.max_retained(max_ret_q),
		.result      (result),
		.empty       (empty),
		.pop         (pop)
	);
endmodule
`default_nettype wire

>>> sv/srsp_fifo.sv
// Small register queue between the front and back of the parser.
// No package dependency; generic width and depth.
`timescale 1ns / 1ps
`default_nettype none
module srsp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	// store incoming transfer
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end
endmodule
`default_nettype wire

>>> sv/srsp_front.sv
// Front end: accepts stream bytes, classifies them and queues them for the back end.
// Depends on srsp_pkg and srsp_fifo.
`timescale 1ns / 1ps
`default_nettype none
module srsp_front #(
	parameter int QUEUE_DEPTH = srsp_pkg::DEF_QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire srsp_pkg::item_t item,
	output logic                 full,
	input  wire logic            take,
	output srsp_pkg::entry_t     entry,
	output logic                 entry_empty
);
	import srsp_pkg::*;

	entry_t cls;

	// classify the byte
	always_comb begin
		cls.data_byte = item.data_byte;
		cls.eos       = item.end_of_output;
		cls.is_nul    = (item.data_byte == 8'd0);
		cls.is_digit  = (item.data_byte >= CH_ZERO) && (item.data_byte <= 8'h39);
		cls.is_space  = (item.data_byte == CH_SPACE);
		cls.digit     = 4'(item.data_byte - CH_ZERO);
	end

	srsp_fifo #(
		.WIDTH($bits(entry_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(cls),
		.full   (full),
		.rd_en  (take),
		.rd_data(entry),
		.empty  (entry_empty)
	);
endmodule
`default_nettype wire

>>> sv/srsp_back.sv
// Back end: record parser state machine, counters and the summary output register.
// Depends on srsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srsp_back #(
	parameter int COUNT_WIDTH = srsp_pkg::DEF_COUNT_WIDTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire srsp_pkg::entry_t entry,
	input  wire logic             entry_empty,
	output logic                  take,
	input  wire logic [31:0]      max_retained,
	output srsp_pkg::result_t     result,
	output logic                  empty,
	input  wire logic             pop
);
	import srsp_pkg::*;

	logic [3:0]  phase_q, phase_d;
	logic [2:0]  kind_q, kind_d;
	logic [3:0]  fidx_q, fidx_d;
	logic [7:0]  flen_q, flen_d;
	logic [4:0]  mpos_q, mpos_d;
	logic [3:0]  cand_q, cand_d;
	logic        vmf_q, vmf_d;
	logic [15:0] stat_q, stat_d;
	logic [63:0] acc_q, acc_d;
	logic        pend_q, pend_d;
	logic [2:0]  err_q, err_d;
	logic [COUNT_WIDTH-1:0] staged_q, staged_d, mod_q, mod_d;
	logic [COUNT_WIDTH-1:0] conf_q, conf_d, untr_q, untr_d;
	logic [63:0] ahead_q, ahead_d, behind_q, behind_d;
	logic [31:0] ret_q, ret_d;
	logic        unborn_q, unborn_d, det_q, det_d, trunc_q, trunc_d;
	logic        out_valid_q;
	result_t     result_q, summary;
	logic [2:0]  sum_err;

	logic        do_clr, to_rename, do_retain, ovf, emit;
	logic [67:0] prod;
	logic [7:0]  b;
	logic [3:0]  need, cand_m;
	logic [4:0]  mpos_n;
	logic        word_ok;

	assign b      = entry.data_byte;
	assign emit   = take && entry.eos;
	assign take   = !entry_empty && (!entry.eos || !out_valid_q || pop);
	assign empty  = !out_valid_q;
	assign result = result_q;

	// digit accumulate: acc*10 + d with carry-out as overflow
	assign prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {64'd0, entry.digit};
	assign ovf  = |prod[67:64];
	assign need = (kind_q == K_ORD) ? 4'd7 : ((kind_q == K_REN) ? 4'd8 : 4'd9);
	assign mpos_n = mpos_q + 5'd1;

	// narrow the header prefix candidates by this byte
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cand_m[i] = cand_q[i] && (mpos_q < prefix_len(2'(i)))
				&& (b == prefix_char(2'(i), mpos_q));
		end
		if (cand_q[0]) begin
			word_ok = (flen_q < 8'd9) && (b == word_char(1'b1, flen_q[3:0]));
		end else begin
			word_ok = (flen_q < 8'd10) && (b == word_char(1'b0, flen_q[3:0]));
		end
	end

	// summary from the current stream state
	always_comb begin
		sum_err = err_q;
		if (err_q == ERR_NONE) begin
			if (phase_q == PH_RENAME_SRC) begin
				sum_err = ERR_NO_SOURCE;
			end else if (phase_q != PH_START) begin
				sum_err = ERR_NO_TERM;
			end
		end
		summary.error_code       = sum_err;
		summary.staged_count     = 32'(staged_q);
		summary.modified_count   = 32'(mod_q);
		summary.conflicted_count = 32'(conf_q);
		summary.untracked_count  = 32'(untr_q);
		summary.ahead            = (sum_err != ERR_NONE) ? 64'd0 : ahead_q;
		summary.behind           = (sum_err != ERR_NONE) ? 64'd0 : behind_q;
		summary.unborn           = unborn_q;
		summary.detached         = det_q;
		summary.retained_count   = ret_q;
		summary.files_truncated  = trunc_q;
	end

	// parse one byte
	always_comb begin
		phase_d = phase_q; kind_d = kind_q; fidx_d = fidx_q; flen_d = flen_q;
		mpos_d = mpos_q; cand_d = cand_q; vmf_d = vmf_q; stat_d = stat_q;
		acc_d = acc_q; pend_d = pend_q; err_d = err_q;
		staged_d = staged_q; mod_d = mod_q; conf_d = conf_q; untr_d = untr_q;
		ahead_d = ahead_q; behind_d = behind_q; ret_d = ret_q;
		unborn_d = unborn_q; det_d = det_q; trunc_d = trunc_q;
		do_clr = 1'b0; to_rename = 1'b0; do_retain = 1'b0;

		if (take && !entry.eos && phase_q != PH_HALT) begin
			if (entry.is_nul) begin
				// end of record
				case (phase_q)
					PH_START, PH_FILE_SECOND: begin
						err_d = ERR_BAD_RECORD; phase_d = PH_HALT;
					end
					PH_HDR_WORD: begin
						if (flen_q == 8'd0) begin
							err_d = ERR_BAD_HEADER; phase_d = PH_HALT;
						end else begin
							if (cand_q[0]) begin
								if (vmf_q && flen_q == 8'd9) unborn_d = 1'b1;
							end else begin
								if (vmf_q && flen_q == 8'd10) det_d = 1'b1;
							end
							do_clr = 1'b1;
						end
					end
					PH_HDR_UPSTREAM: begin
						if (flen_q == 8'd0) begin
							err_d = ERR_BAD_HEADER; phase_d = PH_HALT;
						end else begin
							do_clr = 1'b1;
						end
					end
					PH_AB_AHEAD, PH_AB_DASH: begin
						err_d = ERR_BAD_HEADER; phase_d = PH_HALT;
					end
					PH_AB_BEHIND: begin
						if (flen_q == 8'd0) begin
							err_d = ERR_BAD_HEADER; phase_d = PH_HALT;
						end else begin
							behind_d = acc_q;
							do_clr = 1'b1;
						end
					end
					PH_FILE_FIELDS: begin
						if (kind_q == K_UNTR) begin
							if (flen_q == 8'd0) begin
								err_d = ERR_BAD_RECORD; phase_d = PH_HALT;
							end else begin
								untr_d = untr_q + COUNT_WIDTH'(1);
								do_retain = 1'b1; do_clr = 1'b1;
							end
						end else if (fidx_q < need || flen_q == 8'd0) begin
							err_d = ERR_BAD_RECORD; phase_d = PH_HALT;
						end else if (kind_q == K_UNM) begin
							conf_d = conf_q + COUNT_WIDTH'(1);
							do_retain = 1'b1; do_clr = 1'b1;
						end else begin
							if (stat_q[7:0] != CH_DOT) staged_d = staged_q + COUNT_WIDTH'(1);
							if (stat_q[15:8] != CH_DOT) mod_d = mod_q + COUNT_WIDTH'(1);
							do_clr = 1'b1;
							if (kind_q == K_ORD) begin
								do_retain = 1'b1;
							end else begin
								to_rename = 1'b1;
							end
						end
					end
					PH_SKIP: begin
						if (pend_q) begin
							err_d = (kind_q == K_HDR) ? ERR_BAD_HEADER : ERR_BAD_RECORD;
							phase_d = PH_HALT;
						end else begin
							do_clr = 1'b1;
						end
					end
					PH_RENAME_SRC: begin
						if (flen_q == 8'd0) begin
							err_d = ERR_NO_SOURCE; phase_d = PH_HALT;
						end else begin
							do_retain = 1'b1; do_clr = 1'b1;
						end
					end
					default: do_clr = 1'b1;
				endcase
			end else begin
				// take a data byte
				case (phase_q)
					PH_START: begin
						if (b == CH_HASH) begin
							kind_d = K_HDR; cand_d = 4'hf; mpos_d = 5'd1;
							phase_d = PH_HDR_PREFIX;
						end else if (b == CH_ONE || b == CH_TWO || b == CH_U || b == CH_QUEST) begin
							kind_d = (b == CH_ONE) ? K_ORD : ((b == CH_TWO) ? K_REN :
								((b == CH_U) ? K_UNM : K_UNTR));
							phase_d = PH_FILE_SECOND;
						end else if (b == CH_BANG) begin
							kind_d = K_IGN; phase_d = PH_SKIP;
						end else begin
							kind_d = K_NONE; pend_d = 1'b1; phase_d = PH_SKIP;
						end
					end
					PH_HDR_PREFIX: begin
						cand_d = cand_m;
						mpos_d = mpos_n;
						if (cand_m == 4'd0) begin
							phase_d = PH_HDR_OTHER;
						end else if (cand_m[0] && prefix_len(2'd0) == mpos_n) begin
							cand_d = 4'b0001; flen_d = '0; acc_d = '0; vmf_d = 1'b1;
							phase_d = PH_HDR_WORD;
						end else if (cand_m[1] && prefix_len(2'd1) == mpos_n) begin
							cand_d = 4'b0010; flen_d = '0; acc_d = '0; vmf_d = 1'b1;
							phase_d = PH_HDR_WORD;
						end else if (cand_m[2] && prefix_len(2'd2) == mpos_n) begin
							cand_d = 4'b0100; flen_d = '0; acc_d = '0; vmf_d = 1'b1;
							phase_d = PH_HDR_UPSTREAM;
						end else if (cand_m[3] && prefix_len(2'd3) == mpos_n) begin
							cand_d = 4'b1000; flen_d = '0; acc_d = '0; vmf_d = 1'b1;
							phase_d = PH_AB_AHEAD;
						end
					end
					PH_HDR_WORD: begin
						if (!word_ok) vmf_d = 1'b0;
						if (flen_q != 8'hff) flen_d = flen_q + 8'd1;
					end
					PH_HDR_UPSTREAM, PH_RENAME_SRC: begin
						if (flen_q != 8'hff) flen_d = flen_q + 8'd1;
					end
					PH_AB_AHEAD: begin
						if (entry.is_digit) begin
							if (ovf) begin
								pend_d = 1'b1; phase_d = PH_SKIP;
							end else begin
								acc_d = prod[63:0];
								if (flen_q != 8'hff) flen_d = flen_q + 8'd1;
							end
						end else if (entry.is_space && flen_q != 8'd0) begin
							ahead_d = acc_q; phase_d = PH_AB_DASH;
						end else begin
							pend_d = 1'b1; phase_d = PH_SKIP;
						end
					end
					PH_AB_DASH: begin
						if (b == CH_DASH) begin
							acc_d = '0; flen_d = '0; phase_d = PH_AB_BEHIND;
						end else begin
							pend_d = 1'b1; phase_d = PH_SKIP;
						end
					end
					PH_AB_BEHIND: begin
						if (!entry.is_digit || ovf) begin
							pend_d = 1'b1; phase_d = PH_SKIP;
						end else begin
							acc_d = prod[63:0];
							if (flen_q != 8'hff) flen_d = flen_q + 8'd1;
						end
					end
					PH_FILE_SECOND: begin
						if (kind_q == K_UNTR && !entry.is_space) begin
							pend_d = 1'b1; phase_d = PH_SKIP;
						end else begin
							fidx_d = '0; flen_d = '0; phase_d = PH_FILE_FIELDS;
						end
					end
					PH_FILE_FIELDS: begin
						if (kind_q != K_UNTR && fidx_q < need && entry.is_space) begin
							if (flen_q == 8'd0 || (fidx_q == 4'd0 && flen_q != 8'd2)
								|| (fidx_q == 4'd1 && flen_q != 8'd4)) begin
								pend_d = 1'b1; phase_d = PH_SKIP;
							end else begin
								fidx_d = fidx_q + 4'd1; flen_d = '0;
							end
						end else begin
							if (kind_q != K_UNTR && fidx_q < need && fidx_q == 4'd0) begin
								if (flen_q == 8'd0) stat_d[7:0] = b;
								else if (flen_q == 8'd1) stat_d[15:8] = b;
							end
							if (flen_q != 8'hff) flen_d = flen_q + 8'd1;
						end
					end
					default: ;
				endcase
			end
		end

		// count a retained file
		if (do_retain) begin
			if (ret_q < max_retained) ret_d = ret_q + 32'd1;
			else trunc_d = 1'b1;
		end

		// drop per-record state
		if (do_clr || emit) begin
			phase_d = to_rename ? PH_RENAME_SRC : PH_START;
			kind_d = K_NONE; fidx_d = '0; flen_d = '0; mpos_d = '0; cand_d = 4'hf;
			vmf_d = 1'b0; stat_d = '0; acc_d = '0; pend_d = 1'b0;
		end

		// drop stream state after the summary
		if (emit) begin
			err_d = ERR_NONE; staged_d = '0; mod_d = '0; conf_d = '0; untr_d = '0;
			ahead_d = '0; behind_d = '0; ret_d = '0;
			unborn_d = 1'b0; det_d = 1'b0; trunc_d = 1'b0;
		end
	end

	// hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START; kind_q <= K_NONE; fidx_q <= '0; flen_q <= '0;
			mpos_q <= '0; cand_q <= 4'hf; vmf_q <= 1'b0; stat_q <= '0;
			acc_q <= '0; pend_q <= 1'b0; err_q <= ERR_NONE;
			staged_q <= '0; mod_q <= '0; conf_q <= '0; untr_q <= '0;
			ahead_q <= '0; behind_q <= '0; ret_q <= '0;
			unborn_q <= 1'b0; det_q <= 1'b0; trunc_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d; kind_q <= kind_d; fidx_q <= fidx_d; flen_q <= flen_d;
			mpos_q <= mpos_d; cand_q <= cand_d; vmf_q <= vmf_d; stat_q <= stat_d;
			acc_q <= acc_d; pend_q <= pend_d; err_q <= err_d;
			staged_q <= staged_d; mod_q <= mod_d; conf_q <= conf_d; untr_q <= untr_d;
			ahead_q <= ahead_d; behind_q <= behind_d; ret_q <= ret_d;
			unborn_q <= unborn_d; det_q <= det_d; trunc_q <= trunc_d;
			if (emit) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	// load the summary register
	always_ff @(posedge clk) begin
		if (emit) result_q <= summary;
	end
endmodule
`default_nettype wire

>>> sv/srsp_checker.sv
// Port-level checks for the status record stream parser, bound to its top level.
// Depends on srsp_pkg and status_record_stream_parser.
`timescale 1ns / 1ps
`default_nettype none
module srsp_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire srsp_pkg::result_t result,
	input wire logic              empty,
	input wire logic              pop,
	input wire logic [31:0]       prdata
);
	import srsp_pkg::*;

	// error codes stay within the defined set
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.error_code <= ERR_NO_SOURCE))
		else $error("error code out of range");

	// ahead and behind are meaningless on error and must be zero
	a_ab_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.error_code != ERR_NONE) |-> (result.ahead == 64'd0
			&& result.behind == 64'd0))
		else $error("ahead/behind nonzero with error");

	// retained never passes the configured limit
	a_ret_limit: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.retained_count <= prdata))
		else $error("retained count above limit");

	// a waiting summary holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("summary changed while waiting");
endmodule

bind status_record_stream_parser srsp_checker u_srsp_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.result(result),
	.empty (empty),
	.pop   (pop),
	.prdata(prdata)
);
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for status_record_stream_parser: byte streams of status records,
// summaries checked against an in-bench parser model. Depends on srsp_pkg and the block RTL.
`timescale 1ns / 1ps
module tb_top;
	import srsp_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        push;
	item_t       item;
	logic        full;
	result_t     result;
	logic        empty;
	logic        pop;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	status_record_stream_parser dut (
		.clk(clk), .arst_n(arst_n), .push(push), .item(item), .full(full),
		.result(result), .empty(empty), .pop(pop), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// parser model state
	logic [3:0]  ph;
	logic [2:0]  kind;
	logic [3:0]  fidx;
	logic [7:0]  flen;
	logic [4:0]  mpos;
	logic [3:0]  cand;
	logic        word_ok;
	logic [15:0] xy;
	logic [63:0] acc;
	logic        pend_bad;
	logic [2:0]  lerr;
	logic [31:0] n_staged, n_modified, n_conflicted, n_untracked, n_retained;
	logic [63:0] ahead_v, behind_v;
	logic        f_unborn, f_detached, f_trunc;
	logic [31:0] max_retained;

	string hdr_pfx[4] = '{"# branch.oid ", "# branch.head ", "# branch.upstream ",
		"# branch.ab +"};

	result_t     expected_summaries[$];
	logic [7:0]  stream_q[$];
	int          fails = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_left = 0;
	int          bytes_sent = 0;
	int          streams_sent = 0;
	int          summaries_seen = 0;
	int          error_summaries = 0;

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL status_record_stream_parser");
		$finish;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		fails++;
		$display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
	endtask

	// ---------------- parser model ----------------
	task automatic clear_record();
		ph = PH_START; kind = K_NONE; fidx = 0; flen = 0; mpos = 0; cand = 4'hF;
		word_ok = 0; xy = 0; acc = 0; pend_bad = 0;
	endtask

	task automatic clear_stream();
		clear_record();
		lerr = ERR_NONE;
		n_staged = 0; n_modified = 0; n_conflicted = 0; n_untracked = 0; n_retained = 0;
		ahead_v = 0; behind_v = 0; f_unborn = 0; f_detached = 0; f_trunc = 0;
	endtask

	task automatic halt_with(input logic [2:0] code);
		lerr = code;
		ph = PH_HALT;
	endtask

	task automatic mark_bad();
		pend_bad = 1;
		ph = PH_SKIP;
	endtask

	task automatic grow_field();
		if (flen < 8'd255)
			flen++;
	endtask

	task automatic retain_file();
		if (n_retained < max_retained)
			n_retained++;
		else
			f_trunc = 1;
	endtask

	function automatic int prefix_size(input int i);
		return hdr_pfx[i].len();
	endfunction

	function automatic int fields_for_kind();
		return kind == K_ORD ? 7 : (kind == K_REN ? 8 : 9);
	endfunction

	// accumulate one decimal digit; 0 on 64-bit overflow
	task automatic add_digit(input logic [7:0] b, output bit ok);
		logic [63:0] d;
		d = 64'(b - CH_ZERO);
		ok = !(acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10);
		if (ok) begin
			acc = acc * 64'd10 + d;
			grow_field();
		end
	endtask

	task automatic close_record();
		case (ph)
			PH_START: begin
				halt_with(ERR_BAD_RECORD);
				return;
			end
			PH_HDR_WORD: begin
				if (flen == 0) begin
					halt_with(ERR_BAD_HEADER);
					return;
				end
				if (cand[0]) begin
					if (word_ok && flen == 8'd9) f_unborn = 1;
				end else begin
					if (word_ok && flen == 8'd10) f_detached = 1;
				end
			end
			PH_HDR_UPSTREAM: begin
				if (flen == 0) begin
					halt_with(ERR_BAD_HEADER);
					return;
				end
			end
			PH_AB_AHEAD, PH_AB_DASH: begin
				halt_with(ERR_BAD_HEADER);
				return;
			end
			PH_AB_BEHIND: begin
				if (flen == 0) begin
					halt_with(ERR_BAD_HEADER);
					return;
				end
				behind_v = acc;
			end
			PH_FILE_SECOND: begin
				halt_with(ERR_BAD_RECORD);
				return;
			end
			PH_FILE_FIELDS: begin
				if (kind == K_UNTR) begin
					if (flen == 0) begin
						halt_with(ERR_BAD_RECORD);
						return;
					end
					n_untracked++;
					retain_file();
				end else if (fidx < fields_for_kind() || flen == 0) begin
					halt_with(ERR_BAD_RECORD);
					return;
				end else if (kind == K_UNM) begin
					n_conflicted++;
					retain_file();
				end else begin
					if (xy[7:0] != CH_DOT) n_staged++;
					if (xy[15:8] != CH_DOT) n_modified++;
					if (kind == K_REN) begin
						clear_record();
						ph = PH_RENAME_SRC;
						return;
					end
					retain_file();
				end
			end
			PH_SKIP: begin
				if (pend_bad) begin
					halt_with(kind == K_HDR ? ERR_BAD_HEADER : ERR_BAD_RECORD);
					return;
				end
			end
			PH_RENAME_SRC: begin
				if (flen == 0) begin
					halt_with(ERR_NO_SOURCE);
					return;
				end
				retain_file();
			end
			default: ;
		endcase
		clear_record();
	endtask

	task automatic take_byte(input logic [7:0] b);
		bit    ok;
		string w;
		int    wl;
		case (ph)
			PH_START: begin
				if (b == CH_HASH) begin
					kind = K_HDR; cand = 4'hF; mpos = 1; ph = PH_HDR_PREFIX;
				end else if (b == CH_ONE || b == CH_TWO || b == CH_U || b == CH_QUEST) begin
					kind = b == CH_ONE ? K_ORD : (b == CH_TWO ? K_REN :
						(b == CH_U ? K_UNM : K_UNTR));
					ph = PH_FILE_SECOND;
				end else if (b == CH_BANG) begin
					kind = K_IGN; ph = PH_SKIP;
				end else begin
					kind = K_NONE;
					mark_bad();
				end
			end
			PH_HDR_PREFIX: begin
				for (int i = 0; i < 4; i++)
					if (cand[i] && !(mpos < prefix_size(i) && b == hdr_pfx[i][mpos]))
						cand[i] = 0;
				mpos++;
				if (cand == 0)
					ph = PH_HDR_OTHER;
				else
					for (int i = 0; i < 4; i++)
						if (cand[i] && prefix_size(i) == mpos) begin
							cand = 4'(1 << i);
							flen = 0; acc = 0; word_ok = 1;
							ph = i < 2 ? PH_HDR_WORD : (i == 2 ? PH_HDR_UPSTREAM : PH_AB_AHEAD);
							break;
						end
			end
			PH_HDR_WORD: begin
				w = cand[0] ? "(initial)" : "(detached)";
				wl = cand[0] ? 9 : 10;
				if (!(flen < wl && b == w[flen]))
					word_ok = 0;
				grow_field();
			end
			PH_HDR_UPSTREAM, PH_RENAME_SRC: grow_field();
			PH_AB_AHEAD: begin
				if (b >= "0" && b <= "9") begin
					add_digit(b, ok);
					if (!ok) mark_bad();
				end else if (b == CH_SPACE && flen > 0) begin
					ahead_v = acc;
					ph = PH_AB_DASH;
				end else begin
					mark_bad();
				end
			end
			PH_AB_DASH: begin
				if (b == CH_DASH) begin
					acc = 0; flen = 0; ph = PH_AB_BEHIND;
				end else begin
					mark_bad();
				end
			end
			PH_AB_BEHIND: begin
				if (b >= "0" && b <= "9") begin
					add_digit(b, ok);
					if (!ok) mark_bad();
				end else begin
					mark_bad();
				end
			end
			PH_FILE_SECOND: begin
				if (kind == K_UNTR && b != CH_SPACE) begin
					mark_bad();
				end else begin
					fidx = 0; flen = 0; ph = PH_FILE_FIELDS;
				end
			end
			PH_FILE_FIELDS: begin
				if (kind != K_UNTR && fidx < fields_for_kind()) begin
					if (b == CH_SPACE) begin
						if (flen == 0 || (fidx == 0 && flen != 2) || (fidx == 1 && flen != 4))
							mark_bad();
						else begin
							fidx++;
							flen = 0;
						end
						return;
					end
					if (fidx == 0 && flen == 0)
						xy[7:0] = b;
					else if (fidx == 0 && flen == 1)
						xy[15:8] = b;
				end
				grow_field();
			end
			default: ;
		endcase
	endtask

	// advance the model by one accepted transfer
	task automatic predict_summary(input item_t it);
		result_t r;
		logic [2:0] e;
		if (it.end_of_output) begin
			e = lerr;
			if (e == ERR_NONE) begin
				if (ph == PH_RENAME_SRC) e = ERR_NO_SOURCE;
				else if (ph != PH_START) e = ERR_NO_TERM;
			end
			r.error_code = e;
			r.staged_count = n_staged;
			r.modified_count = n_modified;
			r.conflicted_count = n_conflicted;
			r.untracked_count = n_untracked;
			r.ahead = e != ERR_NONE ? 64'd0 : ahead_v;
			r.behind = e != ERR_NONE ? 64'd0 : behind_v;
			r.unborn = f_unborn;
			r.detached = f_detached;
			r.retained_count = n_retained;
			r.files_truncated = f_trunc;
			if (e != ERR_NONE) error_summaries++;
			expected_summaries.push_back(r);
			clear_stream();
		end else if (ph != PH_HALT) begin
			if (it.data_byte == 8'd0)
				close_record();
			else
				take_byte(it.data_byte);
		end
	endtask

	// ---------------- result side ----------------
	// hold off the receiver for a counted stretch
	always @(posedge clk)
		if (hold_left > 0)
			hold_left <= hold_left - 1;

	always @(negedge clk)
		pop <= arst_n && hold_left == 0 && ($urandom_range(99) >= recv_idle_pct);

	task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
		if (got !== want)
			report(name, got, want);
	endtask

	// compare each summary transfer with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			summaries_seen++;
			if (expected_summaries.size() == 0) begin
				report("unexpected summary", result.error_code, 0);
			end else begin
				want = expected_summaries.pop_front();
				check_field("error_code", result.error_code, want.error_code);
				check_field("staged_count", result.staged_count, want.staged_count);
				check_field("modified_count", result.modified_count, want.modified_count);
				check_field("conflicted_count", result.conflicted_count, want.conflicted_count);
				check_field("untracked_count", result.untracked_count, want.untracked_count);
				check_field("ahead", result.ahead, want.ahead);
				check_field("behind", result.behind, want.behind);
				check_field("unborn", result.unborn, want.unborn);
				check_field("detached", result.detached, want.detached);
				check_field("retained_count", result.retained_count, want.retained_count);
				check_field("files_truncated", result.files_truncated, want.files_truncated);
			end
		end
	end

	// ---------------- input side ----------------
	task automatic send_item(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		item = it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_summary(it);
		bytes_sent++;
		@(negedge clk);
	endtask

	// send the collected bytes, then end the stream
	task automatic send_stream();
		item_t it;
		foreach (stream_q[i]) begin
			it.data_byte = stream_q[i];
			it.end_of_output = 1'b0;
			send_item(it);
		end
		it.data_byte = 8'($urandom);
		it.end_of_output = 1'b1;
		send_item(it);
		stream_q.delete();
		streams_sent++;
	endtask

	task automatic wait_drained();
		push = 1'b0;
		while (expected_summaries.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic reg_write(input logic [31:0] value);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
		paddr = 2'(REG_MAX_RETAINED * 4); pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		max_retained = value;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	task automatic reg_check();
		psel = 1'b1; penable = 1'b0; pwrite = 1'b0;
		paddr = 2'(REG_MAX_RETAINED * 4);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (prdata !== max_retained)
			report("max_retained_files readback", prdata, max_retained);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0;
	endtask

	// ---------------- record builders ----------------
	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			stream_q.push_back(s[i]);
	endtask

	function automatic logic [7:0] word_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(1, 255)); while (b == CH_SPACE);
		return b;
	endfunction

	task automatic put_word(input int n);
		repeat (n) stream_q.push_back(word_byte());
	endtask

	task automatic put_path(input int n);
		repeat (n) stream_q.push_back(8'($urandom_range(1, 255)));
	endtask

	function automatic logic [7:0] status_byte();
		string s = ".MADRCUT";
		return $urandom_range(7) == 0 ? word_byte() : s[$urandom_range(0, 7)];
	endfunction

	// tracked or unmerged record with nfields fields before the path
	task automatic put_file_record(input logic [7:0] kc, input int nfields);
		stream_q.push_back(kc);
		stream_q.push_back($urandom_range(3) == 0 ? word_byte() : CH_SPACE);
		stream_q.push_back(status_byte());
		stream_q.push_back(status_byte());
		stream_q.push_back(CH_SPACE);
		put_word(4);
		stream_q.push_back(CH_SPACE);
		repeat (nfields - 2) begin
			put_word($urandom_range(1, 3));
			stream_q.push_back(CH_SPACE);
		end
		put_path($urandom_range(1, 4));
		stream_q.push_back(8'd0);
	endtask

	function automatic string rand_count();
		logic [63:0] v;
		v = {32'($urandom), 32'($urandom)} >> $urandom_range(0, 63);
		case ($urandom_range(9))
			0: return "18446744073709551615";
			1: return "18446744073709551616";
			2: return "99999999999999999999";
			default: return $sformatf("%0d", v);
		endcase
	endfunction

	task automatic put_random_record();
		int k;
		k = $urandom_range(99);
		if (k < 20) put_file_record(CH_ONE, 7);
		else if (k < 32) begin
			put_file_record(CH_TWO, 8);
			put_path($urandom_range(1, 4));
			stream_q.push_back(8'd0);
		end else if (k < 42) put_file_record(CH_U, 9);
		else if (k < 55) begin
			put_str("? ");
			put_path($urandom_range(1, 5));
			stream_q.push_back(8'd0);
		end else if (k < 62) begin
			put_str("!");
			put_path($urandom_range(0, 4));
			stream_q.push_back(8'd0);
		end else if (k < 70) begin
			put_str(hdr_pfx[0]);
			if ($urandom_range(1)) put_str("(initial)"); else put_word($urandom_range(1, 10));
			stream_q.push_back(8'd0);
		end else if (k < 78) begin
			put_str(hdr_pfx[1]);
			if ($urandom_range(1)) put_str("(detached)"); else put_word($urandom_range(1, 10));
			stream_q.push_back(8'd0);
		end else if (k < 83) begin
			put_str(hdr_pfx[2]);
			put_path($urandom_range(1, 6));
			stream_q.push_back(8'd0);
		end else if (k < 95) begin
			put_str({hdr_pfx[3], rand_count(), " -", rand_count()});
			stream_q.push_back(8'd0);
		end else begin
			put_str("# ");
			put_path($urandom_range(0, 6));
			stream_q.push_back(8'd0);
		end
	endtask

	// one to four random records, sometimes damaged or cut short
	task automatic build_random_stream();
		int n, pos;
		n = $urandom_range(1, 4);
		repeat (n) put_random_record();
		if ($urandom_range(9) < 3 && stream_q.size() > 0) begin
			pos = $urandom_range(0, stream_q.size() - 1);
			case ($urandom_range(2))
				0: stream_q[pos] = 8'($urandom);
				1: stream_q[pos] = CH_SPACE;
				default: while (stream_q.size() > pos) void'(stream_q.pop_back());
			endcase
		end
	endtask

	// ---------------- tests ----------------
	task automatic test_special_cases();
		send_idle_pct = 20; recv_idle_pct = 20;
		send_stream();
		stream_q.push_back(8'd0); send_stream();
		put_str("1"); stream_q.push_back(8'd0); send_stream();
		put_str("?x"); stream_q.push_back(8'd0); send_stream();
		put_str("? "); stream_q.push_back(8'd0); send_stream();
		put_str("Z"); stream_q.push_back(8'hFF); stream_q.push_back(8'd0); send_stream();
		put_str("# foo"); stream_q.push_back(8'd0);
		put_str(hdr_pfx[0]); put_str("(initial)"); stream_q.push_back(8'd0);
		put_str(hdr_pfx[1]); put_str("(detached)"); stream_q.push_back(8'd0);
		put_str({hdr_pfx[3], "18446744073709551615 -0"}); stream_q.push_back(8'd0);
		send_stream();
		put_str(hdr_pfx[2]); stream_q.push_back(8'd0); send_stream();
		put_str({hdr_pfx[3], "18446744073709551616 -1"}); stream_q.push_back(8'd0);
		send_stream();
		put_str({hdr_pfx[3], "12 34"}); stream_q.push_back(8'd0); send_stream();
		put_str({hdr_pfx[3], "7 -"}); stream_q.push_back(8'd0); send_stream();
		put_str("1 .M"); send_stream();
		put_file_record(CH_TWO, 8); send_stream();
		put_file_record(CH_TWO, 8); stream_q.push_back(8'd0); send_stream();
		put_file_record(CH_TWO, 8); put_str("src"); send_stream();
		put_str("Q"); stream_q.push_back(8'd0); put_str("? a"); stream_q.push_back(8'd0);
		send_stream();
		wait_drained();
	endtask

	task automatic test_retention_limits();
		logic [31:0] limits[4] = '{32'd0, 32'd1, 32'hFFFF_FFFF, MAX_RETAINED_RESET};
		send_idle_pct = 10; recv_idle_pct = 10;
		foreach (limits[i]) begin
			reg_write(limits[i]);
			reg_check();
			repeat (1) begin
				repeat (2) put_file_record(CH_ONE, 7);
				put_str("? ab"); stream_q.push_back(8'd0);
				send_stream();
			end
			wait_drained();
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0; recv_idle_pct = 0;
		@(negedge clk);
		hold_left = 400;
		repeat (10) begin
			put_str("? a"); stream_q.push_back(8'd0);
			send_stream();
		end
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int sidle[3] = '{37, 72, 0};
		int ridle[3] = '{72, 37, 0};
		foreach (sidle[p]) begin
			send_idle_pct = sidle[p]; recv_idle_pct = ridle[p];
			repeat (3) begin
				build_random_stream();
				send_stream();
			end
			wait_drained();
			reg_write(p == 1 ? 32'd2 : 32'd5);
		end
	endtask

	initial begin
		arst_n = 1'b0; push = 1'b0; item = '0; pop = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		max_retained = MAX_RETAINED_RESET;
		clear_stream();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		reg_check();
		test_special_cases();
		test_retention_limits();
		test_backpressure();
		test_random_traffic();
		wait_drained();
		repeat (20) @(negedge clk);
		$display("Sent %0d bytes in %0d streams; checked %0d summaries, %0d with an error code.",
			bytes_sent, streams_sent, summaries_seen, error_summaries);
		$display("Covered headers, file records, renames, retention limits and a full stall.");
		if (fails == 0)
			$display("PASS status_record_stream_parser");
		else
			$display("FAIL status_record_stream_parser");
		$finish;
	end

endmodule
